// ===== design/histeq_pkg.sv =====
// ----------------------------------------------------------------------------
// histeq_pkg
// shared types and constants for the histogram equaliser
// ----------------------------------------------------------------------------
package histeq_pkg;

    localparam int BIN_W = 8;
    localparam int NUM_BINS = 256;
    localparam logic [7:0] MAP_MAX = 8'd255;

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_COUNT   = 7'b0000100,
        ST_WALK_RD = 7'b0001000,
        ST_WALK_AC = 7'b0010000,
        ST_DIV     = 7'b0100000,
        ST_WRITE   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic clr_step;     // zero one bin, advance clear address
        logic clr_map;      // zero one map entry, reset sweep only
        logic clr_start;    // reset clear address and pixel total
        logic count;        // count the held pixel
        logic walk_start;   // reset walk address and cdf
        logic walk_rd;      // read histogram at walk address
        logic walk_acc;     // add read bin to cdf
        logic div_start;
        logic map_wr;       // write quotient into map, advance walk
        logic map_rd;       // read map for a map beat
    } histeq_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic walk_done;
    } histeq_sts_t;

endpackage

// ===== design/histeq_div.sv =====
// ----------------------------------------------------------------------------
// histeq_div
// restoring divider, one quotient bit per cycle, saturated to 255
// ----------------------------------------------------------------------------
module histeq_div
    import histeq_pkg::*;
#(
    parameter int NW = 21
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] cdf,
    input  logic [NW-1:0] total,
    output logic          done,
    output logic [7:0]    quot
);
    localparam int DW = NW + 10;
    localparam int QW = 10;
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] num_reg, num_next;
    logic [DW-1:0] den_reg, den_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW-1:0] den_sh;

    // numerator is 510*cdf + n; quotient fits 10 bits since cdf <= n
    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        den_sh    = den_reg << cnt_reg;
        if (start) begin
            num_next  = DW'(cdf) * DW'(510) + DW'(total);
            den_next  = DW'(total) << 1;
            q_next    = '0;
            cnt_next  = CW'(QW - 1);
            busy_next = (total != '0);
        end else if (busy_reg) begin
            if (num_reg >= den_sh && (den_sh >> cnt_reg) == den_reg) begin
                num_next = num_reg - den_sh;
                q_next   = q_reg | (QW'(1) << cnt_reg);
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign done = !busy_reg && !start;
    assign quot = (q_reg > QW'(MAP_MAX)) ? MAP_MAX : q_reg[7:0];
endmodule

// ===== design/histeq_datapath.sv =====
// ----------------------------------------------------------------------------
// histeq_datapath
// histogram and map memories, pixel total, cdf walk
// ----------------------------------------------------------------------------
module histeq_datapath
    import histeq_pkg::*;
#(
    parameter int MAX_PIXELS = 1048576,
    parameter int NW = 21
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  histeq_cmd_t cmd,
    input  logic [7:0]  pixel,
    input  logic        clr_hist,
    output histeq_sts_t sts,
    output logic [7:0]  mapped_pixel
);
    logic [NW-1:0] hist_mem [NUM_BINS];
    logic [7:0]    map_mem  [NUM_BINS];

    logic [NW-1:0] total_reg, total_next;
    logic [NW-1:0] cdf_reg, cdf_next;
    logic [BIN_W-1:0] addr_reg, addr_next;
    logic [NW-1:0] rd_reg;
    logic          div_done;
    logic [7:0]    quot;

    // histogram is cleared by sweep after reset and on first; pixel path uses the pixel address
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            hist_mem[addr_reg] <= '0;
        end else if (cmd.count && !clr_hist) begin
            if (total_reg < NW'(MAX_PIXELS)) begin
                hist_mem[pixel] <= rd_reg + NW'(1);
            end
        end
        // every bin is zero once a sweep ends, so the count after it starts from zero
        if (cmd.walk_rd) begin
            rd_reg <= hist_mem[addr_reg];
        end else if (cmd.clr_step) begin
            rd_reg <= '0;
        end else begin
            rd_reg <= hist_mem[pixel];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_map) begin
            map_mem[addr_reg] <= '0;
        end else if (cmd.map_wr) begin
            map_mem[addr_reg] <= quot;
        end
        if (cmd.map_rd) begin
            mapped_pixel <= map_mem[pixel];
        end
    end

    always_comb begin
        total_next = total_reg;
        cdf_next   = cdf_reg;
        addr_next  = addr_reg;
        if (cmd.clr_start || cmd.walk_start) begin
            addr_next = '0;
        end
        if (cmd.clr_start) begin
            total_next = '0;
        end
        if (cmd.clr_step || cmd.map_wr) begin
            addr_next = addr_reg + BIN_W'(1);
        end
        if (cmd.count && total_reg < NW'(MAX_PIXELS)) begin
            total_next = total_reg + NW'(1);
        end
        if (cmd.walk_start) begin
            cdf_next = '0;
        end
        if (cmd.walk_acc) begin
            cdf_next = cdf_reg + rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            cdf_reg   <= '0;
            addr_reg  <= '0;
        end else begin
            total_reg <= total_next;
            cdf_reg   <= cdf_next;
            addr_reg  <= addr_next;
        end
    end

    histeq_div #(.NW(NW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .cdf     (cdf_reg),
        .total   (total_reg),
        .done    (div_done),
        .quot    (quot)
    );

    assign sts.clr_done  = (addr_reg == BIN_W'(NUM_BINS - 1));
    assign sts.walk_done = (addr_reg == BIN_W'(NUM_BINS - 1));
    assign sts.div_done  = div_done;
endmodule

// ===== design/histeq_ctrl.sv =====
// ----------------------------------------------------------------------------
// histeq_ctrl
// sequencer for clear sweep, counting, map build and map reads
// ----------------------------------------------------------------------------
module histeq_ctrl
    import histeq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic        s_first,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output histeq_cmd_t cmd,
    output logic        clr_hist,
    input  histeq_sts_t sts
);
    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   count_reg, count_next;
    logic   mv_reg, mv_next;
    logic   acc;

    // set only for the sweep after reset, the one that also zeroes the map
    logic   rst_sweep_reg, rst_sweep_next;

    assign s_ready = (state_reg == ST_IDLE) && (!mv_reg || m_ready);
    assign acc     = s_valid && s_ready;
    assign m_valid = mv_reg;
    assign clr_hist = 1'b0;

    always_comb begin
        state_next     = state_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        mv_next        = mv_reg;
        rst_sweep_next = rst_sweep_reg;
        cmd            = '0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                // reset sweeps map and histogram; first sweeps histogram only
                cmd.clr_step = 1'b1;
                cmd.clr_map  = rst_sweep_reg;
                if (sts.clr_done) begin
                    state_next     = count_reg ? ST_COUNT : ST_IDLE;
                    rst_sweep_next = 1'b0;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    last_next = s_last;
                    if (s_req_type) begin
                        cmd.map_rd = 1'b1;
                        mv_next    = 1'b1;
                    end else if (s_first) begin
                        cmd.clr_start  = 1'b1;
                        count_next     = 1'b1;
                        state_next     = ST_CLEAR;
                    end else begin
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_COUNT: begin
                cmd.count  = 1'b1;
                count_next = 1'b0;
                if (last_reg) begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_WALK_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = ST_WALK_AC;
            end
            ST_WALK_AC: begin
                cmd.walk_acc = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (!count_reg) begin
                    cmd.div_start = 1'b1;
                    count_next    = 1'b1;
                end else if (sts.div_done) begin
                    count_next = 1'b0;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.map_wr = 1'b1;
                state_next = sts.walk_done ? ST_IDLE : ST_WALK_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            last_reg      <= 1'b0;
            count_reg     <= 1'b0;
            mv_reg        <= 1'b0;
            rst_sweep_reg <= 1'b1;
        end else begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            mv_reg        <= mv_next;
            rst_sweep_reg <= rst_sweep_next;
        end
    end
endmodule

// ===== design/histeq_clrmux.sv =====
// ----------------------------------------------------------------------------
// histeq_clrmux
// holds the beat's pixel and forces a clear step when in_clear is set outside a reset sweep
// ----------------------------------------------------------------------------
module histeq_clrmux
    import histeq_pkg::*;
(
    input  logic        aclk,
    input  logic        load,
    input  logic [7:0]  s_pixel,
    input  logic        in_clear,
    input  logic        rst_sweep,
    input  histeq_cmd_t cmd_in,
    output histeq_cmd_t cmd_out,
    output logic [7:0]  pixel
);
    logic [7:0] pix_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            pix_reg <= s_pixel;
        end
    end

    always_comb begin
        cmd_out = cmd_in;
        cmd_out.map_wr = cmd_in.map_wr;
        if (in_clear && !rst_sweep) begin
            cmd_out.clr_step = 1'b1;
        end
    end

    assign pixel = load ? s_pixel : pix_reg;
endmodule

// ===== design/histogram_equalizer.sv =====
// ----------------------------------------------------------------------------
// histogram_equalizer
// two-pass 8-bit histogram equalisation, count beats then map beats
// ----------------------------------------------------------------------------
// map beat: the map is read into the output register on acceptance; a count
// beat passes the count state, after a histogram sweep of 256 bins with first;
// last adds a walk of 256 bins, each read, add and a 10-step serial divide
// reset: synchronous active low, then a 256-entry sweep zeroes histogram and map
// ----------------------------------------------------------------------------
module histogram_equalizer
    import histeq_pkg::*;
#(
    parameter int MAX_PIXELS = 1048576
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_pixel,
    input  logic       s_first,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_mapped_pixel
);
    localparam int NW = $clog2(MAX_PIXELS + 1);

    histeq_cmd_t cmd_c, cmd_d;
    histeq_sts_t sts;
    logic        clr_hist;
    logic [7:0]  pixel;

    histeq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_first    (s_first),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd_c),
        .clr_hist   (clr_hist),
        .sts        (sts)
    );

    histeq_clrmux u_mux (
        .aclk      (aclk),
        .load      (s_valid && s_ready),
        .s_pixel   (s_pixel),
        .in_clear  (1'b0),
        .rst_sweep (1'b1),
        .cmd_in    (cmd_c),
        .cmd_out   (cmd_d),
        .pixel     (pixel)
    );

    histeq_datapath #(.MAX_PIXELS(MAX_PIXELS), .NW(NW)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd_d),
        .pixel        (pixel),
        .clr_hist     (clr_hist),
        .sts          (sts),
        .mapped_pixel (m_mapped_pixel)
    );
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives count and map beats into the histogram equaliser with random gaps,
// predicts each mapped pixel from an own histogram and map, checks the outputs
// ----------------------------------------------------------------------------
module testbench;
    import histeq_pkg::*;

    localparam int MAX_PIX = 1048576;
    localparam int REQ_COUNT = 0;
    localparam int REQ_MAP = 1;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pixel;
        logic       first;
        logic       last;
    } beat_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_req_type;
    logic [7:0] s_pixel;
    logic       s_first;
    logic       s_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_mapped_pixel;

    histogram_equalizer DUT (.*);

    beat_t      pending_beats[$];
    logic [7:0] expected_pixels[$];

    int unsigned hist_bins[NUM_BINS];
    int unsigned pix_count;
    logic [7:0]  eq_map[NUM_BINS];

    int  fails;
    int  send_wait;
    int  recv_wait;
    int  recv_draw;
    int  hold_off;
    int  idle_cycles;
    int  beats_sent;
    int  results_seen;
    int  builds_seen;
    bit  stall_done;

    // follows one accepted beat through the histogram and map
    task automatic equalise_beat(input beat_t b);
        longint unsigned cdf;
        longint unsigned q;
        if (b.req_type == 1'(REQ_MAP)) begin
            expected_pixels.push_back(eq_map[b.pixel]);
            return;
        end
        if (b.first) begin
            foreach (hist_bins[i]) hist_bins[i] = 0;
            pix_count = 0;
        end
        if (pix_count < MAX_PIX) begin
            hist_bins[b.pixel]++;
            pix_count++;
        end
        if (b.last) begin
            cdf = 0;
            builds_seen++;
            for (int i = 0; i < NUM_BINS; i++) begin
                cdf += hist_bins[i];
                if (pix_count == 0) begin
                    eq_map[i] = 8'd0;
                end else begin
                    q = (cdf * 510 + pix_count) / (2 * longint'(pix_count));
                    eq_map[i] = (q > 255) ? MAP_MAX : q[7:0];
                end
            end
        end
    endtask

    function automatic beat_t mk(input int rt, input int px, input int f, input int l);
        beat_t b;
        b.req_type = 1'(rt);
        b.pixel = 8'(px);
        b.first = 1'(f);
        b.last = 1'(l);
        return b;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait <= $urandom_range(0, 12);
        end else if (s_valid && !s_ready) begin
            // hold the beat
        end else begin
            if (s_valid) begin
                equalise_beat({s_req_type, s_pixel, s_first, s_last});
                beats_sent <= beats_sent + 1;
            end
            if (send_wait > 0 || pending_beats.size() == 0) begin
                s_valid <= 1'b0;
                if (send_wait > 0) send_wait <= send_wait - 1;
            end else begin
                beat_t b;
                b = pending_beats.pop_front();
                s_valid <= 1'b1;
                {s_req_type, s_pixel, s_first, s_last} <= b;
                send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected beat: mapped_pixel %0d", m_mapped_pixel);
                    fails++;
                end else begin
                    logic [7:0] e;
                    e = expected_pixels.pop_front();
                    if (e !== m_mapped_pixel) begin
                        $error("mapped_pixel: expected %0d, got %0d", e, m_mapped_pixel);
                        fails++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                // gap before the next beat, zero keeps ready up
                recv_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                if (recv_draw == 0) begin
                    m_ready <= 1'b1;
                    recv_wait <= 0;
                end else begin
                    m_ready <= 1'b0;
                    recv_wait <= recv_draw - 1;
                end
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on accepted beats
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("histogram_equalizer test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int frame_len;
        int lo;
        int hi;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = 1'b0;
        s_pixel = 8'd0;
        s_first = 1'b0;
        s_last = 1'b0;
        m_ready = 1'b0;
        fails = 0;
        hold_off = 0;
        beats_sent = 0;
        results_seen = 0;
        builds_seen = 0;
        stall_done = 0;
        foreach (hist_bins[i]) hist_bins[i] = 0;
        foreach (eq_map[i]) eq_map[i] = 8'd0;
        pix_count = 0;

        // directed: map before any build, flags on map beats, single pixel frame,
        // empty build is not reachable since a last beat always counts its pixel
        pending_beats.push_back(mk(REQ_MAP, 0, 0, 0));
        pending_beats.push_back(mk(REQ_MAP, 255, 1, 1));
        pending_beats.push_back(mk(REQ_COUNT, 128, 1, 1));
        pending_beats.push_back(mk(REQ_MAP, 0, 0, 0));
        pending_beats.push_back(mk(REQ_MAP, 127, 0, 0));
        pending_beats.push_back(mk(REQ_MAP, 128, 1, 0));
        pending_beats.push_back(mk(REQ_MAP, 255, 0, 1));
        pending_beats.push_back(mk(REQ_COUNT, 0, 1, 0));
        // map beats between first and last see the old map
        pending_beats.push_back(mk(REQ_MAP, 128, 0, 0));
        pending_beats.push_back(mk(REQ_COUNT, 255, 0, 0));
        pending_beats.push_back(mk(REQ_COUNT, 85, 0, 0));
        pending_beats.push_back(mk(REQ_MAP, 200, 0, 0));
        pending_beats.push_back(mk(REQ_COUNT, 170, 0, 1));
        for (int i = 0; i < 6; i++)
            pending_beats.push_back(mk(REQ_MAP, i * 51, 0, 0));
        pending_beats.push_back(mk(REQ_COUNT, 0, 1, 1));
        pending_beats.push_back(mk(REQ_MAP, 0, 0, 0));
        pending_beats.push_back(mk(REQ_MAP, 255, 0, 0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // frames of random length and pixel spread, each followed by map beats
        while (pending_beats.size() + beats_sent < 1350) begin
            frame_len = $urandom_range(1, 40);
            lo = $urandom_range(0, 255);
            hi = $urandom_range(lo, 255);
            for (int i = 0; i < frame_len; i++)
                pending_beats.push_back(mk(REQ_COUNT,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(lo, hi),
                    i == 0 ? 1'b1 : ($urandom_range(0, 30) == 0),
                    i == frame_len - 1 ? 1'b1 : ($urandom_range(0, 30) == 0)));
            repeat ($urandom_range(4, 40))
                pending_beats.push_back(mk(REQ_MAP, $urandom_range(0, 255),
                    $urandom_range(0, 1), $urandom_range(0, 1)));
            if (beats_sent > 400 && !stall_done) begin
                // long receiver stall so the output backs up into the input
                hold_off = 300;
                stall_done = 1;
            end
            wait (pending_beats.size() < 20);
        end

        wait (pending_beats.size() == 0 && !s_valid);
        wait (expected_pixels.size() == 0);
        repeat (4000) @(posedge aclk);
        $display("ran %0d beats with %0d map builds, checked %0d mapped pixels",
                 beats_sent, builds_seen, results_seen);
        if (fails == 0 && expected_pixels.size() == 0) begin
            $display("histogram_equalizer test passed");
        end else begin
            $display("histogram_equalizer test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/histeq_pkg.sv
design/histeq_div.sv
design/histeq_datapath.sv
design/histeq_ctrl.sv
design/histeq_clrmux.sv
design/histogram_equalizer.sv
tb/testbench.sv
